[rtl/itoa_pkg.sv]
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants, types and helpers for the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int MAX_WIDTH_DEF = 32;

  // conversion selector codes
  localparam logic [1:0] FUNC_UDEC = 2'd0;
  localparam logic [1:0] FUNC_SDEC = 2'd1;
  localparam logic [1:0] FUNC_HEX  = 2'd2;

  // floor(n / 10) == (n * RECIP10) >> RECIP_SHIFT for every 32-bit n
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // ten decimal digits of four bits each
  localparam int DIG_BITS = 40;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UPA   = 8'h41;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic prep;
    logic emit_sign;
    logic emit_fill;
    logic emit_digit;
  } itoa_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic neg;
    logic fill_nz;
    logic fill_last;
    logic digit_last;
  } itoa_status_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = CH_UPA + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

[rtl/itoa_ctrl.sv]
// ----------------------------------------------------------------------------
// itoa_ctrl
// Controller: sequences digit extraction, fill calculation and character
// emission for one transaction.
// ----------------------------------------------------------------------------
module itoa_ctrl
  import itoa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  itoa_status_t status,
  output itoa_cmd_t    cmd,
  output logic         busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_SIGN  = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;
  localparam logic [2:0] S_DIGIT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = status.conv_done ? S_PREP : S_MUL;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_SIGN;
      end
      S_SIGN: begin
        // sign cycle passes silently for non-negative values
        cmd.emit_sign = status.neg;
        state_next    = status.fill_nz ? S_FILL : S_DIGIT;
      end
      S_FILL: begin
        cmd.emit_fill = 1'b1;
        if (status.fill_last) begin
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: begin
        cmd.emit_digit = 1'b1;
        if (status.digit_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

[rtl/itoa_dp.sv]
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: operand registers, divide-by-ten by reciprocal multiply, digit
// shift register, fill counter and the registered character output.
// ----------------------------------------------------------------------------
module itoa_dp
  import itoa_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  itoa_cmd_t    cmd,
  output itoa_status_t status,
  input  logic [1:0]   func,
  input  logic [31:0]  value,
  input  logic [5:0]   width,
  input  logic         zero_fill,
  output logic [7:0]   out_char,
  output logic         last,
  output logic         strobe
);

  localparam int FW = $clog2(MAX_WIDTH + 1);

  logic [31:0]         mag;
  logic                hex;
  logic                neg;
  logic                zfill;
  logic [FW-1:0]       field;
  logic [FW-1:0]       fill_cnt;
  logic [3:0]          nd;
  logic [DIG_BITS-1:0] digbuf;
  logic [63:0]         prod;

  logic                load_neg;
  logic [FW-1:0]       field_sat;
  logic [31:0]         quot;
  logic [31:0]         rem_full;
  logic [3:0]          digit;
  logic [31:0]         mag_next;
  logic [4:0]          used;

  assign load_neg  = (func == FUNC_SDEC) && value[31];
  assign field_sat = (32'(width) > 32'(MAX_WIDTH)) ? FW'(MAX_WIDTH) : FW'(width);

  assign quot     = {3'b0, prod[63:RECIP_SHIFT]};
  assign rem_full = mag - ((quot << 3) + (quot << 1));
  assign digit    = hex ? mag[3:0] : rem_full[3:0];
  assign mag_next = hex ? (mag >> 4) : quot;
  assign used     = {1'b0, nd} + {4'b0, neg};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hex   <= func[1];
      neg   <= load_neg;
      zfill <= zero_fill;
      field <= field_sat;
      mag   <= load_neg ? (32'd0 - value) : value;
      nd    <= '0;
    end
    if (cmd.mul) begin
      prod <= mag * RECIP10;
    end
    if (cmd.step) begin
      // least significant digit first, so the top nibble ends as the msd
      digbuf <= {digit, digbuf[DIG_BITS-1:4]};
      mag    <= mag_next;
      nd     <= nd + 4'd1;
    end
    if (cmd.prep) begin
      if (32'(field) > 32'(used)) begin
        fill_cnt <= FW'(32'(field) - 32'(used));
      end else begin
        fill_cnt <= '0;
      end
    end
    if (cmd.emit_fill) begin
      fill_cnt <= fill_cnt - FW'(1);
    end
    if (cmd.emit_digit) begin
      digbuf <= {digbuf[DIG_BITS-5:0], 4'b0};
      nd     <= nd - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign | cmd.emit_fill | cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    last <= cmd.emit_digit && (nd == 4'd1);
    if (cmd.emit_sign) begin
      out_char <= CH_MINUS;
    end else if (cmd.emit_fill) begin
      out_char <= zfill ? CH_ZERO : CH_SPACE;
    end else begin
      out_char <= digit_char(digbuf[DIG_BITS-1 -: 4]);
    end
  end

  assign status.conv_done  = (mag_next == 32'd0);
  assign status.neg        = neg;
  assign status.fill_nz    = (fill_cnt != '0);
  assign status.fill_last  = (fill_cnt == FW'(1));
  assign status.digit_last = (nd == 4'd1);

endmodule

[rtl/integer_to_ascii_formatter_unit.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats a 32-bit value as unsigned decimal, signed decimal or upper-case
// hex text with a minimum field width and space or zero fill.
// ----------------------------------------------------------------------------
// Usage: drive func, value, width and zero_fill with start high; the
// transaction is taken at the edge where start is high and busy is low.
// busy then stays high until the final character has been issued.
// Characters leave on out_char, one per cycle while strobe is high, most
// significant first: '-' for a negative signed value, then fill, then
// digits; last marks the final character. The receiver cannot stall.
// Sequence: each digit takes a 32x32 reciprocal multiply (MUL), then
// quotient and remainder (STEP); a set-up state (PREP) and a sign state
// (SIGN) follow, then a FILL or DIGIT state for each fill or digit
// character; a '-' goes out in the sign state itself. At most 10 digits
// are produced. The next transaction may be accepted in the cycle that
// shows the last character.
// Reset returns the controller to idle and drops strobe; nothing else needs
// clearing.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit
  import itoa_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [31:0] value,
  input  logic [5:0]  width,
  input  logic        zero_fill,
  output logic [7:0]  out_char,
  output logic        last,
  output logic        strobe
);

  itoa_cmd_t    cmd;
  itoa_status_t status;

  itoa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  itoa_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .func      (func),
    .value     (value),
    .width     (width),
    .zero_fill (zero_fill),
    .out_char  (out_char),
    .last      (last),
    .strobe    (strobe)
  );

endmodule

[rtl/itoa_checker.sv]
// ----------------------------------------------------------------------------
// itoa_checker
// Port-level checks on transaction sequencing of the formatter.
// ----------------------------------------------------------------------------
module itoa_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last,
  input logic strobe
);

  // an accepted transaction holds the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepting a transaction");

  // no character directly after acceptance
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !strobe)
    else $error("character issued right after acceptance");

  // characters before the final one come while busy
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final character while idle");

  // the final character coincides with the unit going idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("final character while still busy");

  a_fall_last: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> strobe && last)
    else $error("busy dropped without a final character");

endmodule

bind integer_to_ascii_formatter_unit itoa_checker u_itoa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .last   (last),
  .strobe (strobe)
);

[bench/integer_to_ascii_formatter_unit_tb.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit_tb
// Self-checking bench for the integer-to-ASCII formatter. Each accepted
// transaction is expanded into the characters it should produce, and every
// strobed character is compared in order against that list. A directed set
// covers field extremes and corner cases; random transactions follow, with
// idle gaps on the command side and one pause until the output has drained.
// ----------------------------------------------------------------------------
import itoa_pkg::*;

class char_scoreboard;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_result_t;

  localparam int FIELD_LIMIT = MAX_WIDTH_DEF;

  char_result_t expected_chars[$];
  int           errors;

  function new();
    errors = 0;
  endfunction

  // expand one transaction into its printed characters
  function void note_request(logic [1:0] f, logic [31:0] v, logic [5:0] w, logic z);
    logic [7:0]  digits[$];
    logic [7:0]  text[$];
    logic [31:0] mag;
    logic [31:0] base;
    logic [3:0]  d;
    int          field;
    mag   = v;
    field = (w > FIELD_LIMIT) ? FIELD_LIMIT : int'(w);
    base  = f[1] ? 32'd16 : 32'd10;
    if (f == FUNC_SDEC && mag[31]) begin
      text.push_back(CH_MINUS);
      field--;
      mag = 32'd0 - mag;
    end
    do begin
      d = 4'(mag % base);
      digits.push_front((d < 4'd10) ? (CH_ZERO + 8'(d)) : (CH_UPA + 8'(d) - 8'd10));
      mag = mag / base;
    end while (mag != 32'd0);
    field -= digits.size();
    while (field > 0) begin
      text.push_back(z ? CH_ZERO : CH_SPACE);
      field--;
    end
    foreach (digits[i]) text.push_back(digits[i]);
    foreach (text[k]) expected_chars.push_back('{text[k], k == text.size() - 1});
  endfunction

  function void check_char(logic [7:0] ch, logic last);
    char_result_t exp_c;
    if (expected_chars.size() == 0) begin
      $display("%0t unexpected character: expected none, actual char %h last %b",
               $time, ch, last);
      errors++;
    end else begin
      exp_c = expected_chars.pop_front();
      if (ch !== exp_c.ch) begin
        $display("%0t out_char mismatch: expected %h, actual %h", $time, exp_c.ch, ch);
        errors++;
      end
      if (last !== exp_c.last) begin
        $display("%0t last mismatch: expected %b, actual %b", $time, exp_c.last, last);
        errors++;
      end
    end
  endfunction

  function int pending();
    return expected_chars.size();
  endfunction

endclass

module integer_to_ascii_formatter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_HEX_ALT  = 2'd3;
  localparam int         RANDOM_ITEMS  = 200;
  localparam int         STALL_LIMIT   = 1000;
  localparam int         DRAIN_CYCLES  = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func = FUNC_UDEC;
  logic [31:0] value = 32'd0;
  logic [5:0]  width = 6'd0;
  logic        zero_fill = 1'b0;
  logic [7:0]  out_char;
  logic        last;
  logic        strobe;

  char_scoreboard sb;
  int             stall_count = 0;

  integer_to_ascii_formatter_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .value     (value),
    .width     (width),
    .zero_fill (zero_fill),
    .out_char  (out_char),
    .last      (last),
    .strobe    (strobe)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      sb.check_char(out_char, last);
    end
  end

  // watchdog: cycles with neither a command nor a character taken
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_request(input logic [1:0] f, input logic [31:0] v,
                              input logic [5:0] w, input logic z, input bit may_idle);
    bit taken;
    taken     = 1'b0;
    func      <= f;
    value     <= v;
    width     <= w;
    zero_fill <= z;
    while (!taken) begin
      if (may_idle && $urandom_range(0, 99) < 32) start <= 1'b0;
      else start <= 1'b1;
      @(posedge clk);
      taken = start && !busy;
    end
    sb.note_request(f, v, w, z);
  endtask

  task automatic pick_random(output logic [1:0] f, output logic [31:0] v,
                             output logic [5:0] w, output logic z);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) f = FUNC_UDEC;
    else if (sel < 6) f = FUNC_SDEC;
    else if (sel < 9) f = FUNC_HEX;
    else f = FUNC_HEX_ALT;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(0, 999);
      6:          v = 32'h8000_0000 + $urandom_range(0, 3) - 32'd2;
      7:          v = 32'd0 - $urandom_range(1, 1000);
      8:          v = $urandom >> $urandom_range(0, 31);
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h0000_0000;
          1:       v = 32'hFFFF_FFFF;
          2:       v = 32'd999_999_999 + $urandom_range(0, 2);
          default: v = 32'h7FFF_FFFF;
        endcase
      end
    endcase
    if ($urandom_range(0, 99) < 85) w = 6'($urandom_range(0, 12));
    else w = 6'($urandom_range(0, 63));
    z = 1'($urandom_range(0, 1));
  endtask

  initial begin
    logic [1:0]  f;
    logic [31:0] v;
    logic [5:0]  w;
    logic        z;
    bit          may_idle;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed corner cases
    send_request(FUNC_UDEC, 32'd0,          6'd0,  1'b0, 1'b0);
    send_request(FUNC_UDEC, 32'hFFFF_FFFF,  6'd0,  1'b0, 1'b1);
    send_request(FUNC_UDEC, 32'd42,         6'd8,  1'b0, 1'b1);
    send_request(FUNC_UDEC, 32'd42,         6'd8,  1'b1, 1'b0);
    send_request(FUNC_UDEC, 32'd7,          6'd32, 1'b0, 1'b1);
    send_request(FUNC_UDEC, 32'd1000000000, 6'd33, 1'b1, 1'b0);
    send_request(FUNC_SDEC, 32'h8000_0000,  6'd0,  1'b0, 1'b1);
    send_request(FUNC_SDEC, 32'hFFFF_FFFF,  6'd6,  1'b0, 1'b0);
    send_request(FUNC_SDEC, 32'hFFFF_FFFB,  6'd6,  1'b1, 1'b1);
    send_request(FUNC_SDEC, 32'h7FFF_FFFF,  6'd12, 1'b1, 1'b0);
    send_request(FUNC_SDEC, 32'd0,          6'd1,  1'b0, 1'b0);
    send_request(FUNC_SDEC, 32'hFFFF_FF85,  6'd63, 1'b1, 1'b1);
    send_request(FUNC_SDEC, 32'h8000_0000,  6'd32, 1'b0, 1'b0);
    send_request(FUNC_HEX,  32'hDEAD_BEEF,  6'd0,  1'b0, 1'b1);
    send_request(FUNC_HEX,  32'd0,          6'd32, 1'b1, 1'b0);
    send_request(FUNC_HEX,  32'h0000_00FF,  6'd63, 1'b0, 1'b1);
    send_request(FUNC_HEX,  32'hABCD_EF01,  6'd40, 1'b1, 1'b0);
    send_request(FUNC_HEX,  32'hFFFF_FFFF,  6'd8,  1'b1, 1'b0);
    send_request(FUNC_HEX_ALT, 32'h1234_ABCD, 6'd10, 1'b1, 1'b1);
    send_request(FUNC_HEX_ALT, 32'h8000_0000, 6'd0,  1'b0, 1'b0);
    send_request(FUNC_UDEC, 32'h5555_5555,  6'd21, 1'b1, 1'b0);
    send_request(FUNC_UDEC, 32'hAAAA_AAAA,  6'd42, 1'b0, 1'b1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      may_idle = !(i >= 60 && i < 120);
      if (i == 150) begin
        // hold the command side until every character has drained
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        may_idle = 1'b0;
      end
      pick_random(f, v, w, z);
      send_request(f, v, w, z, may_idle);
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      if (sb.pending() != 0) begin
        $display("%0t characters left over: expected 0, actual %0d", $time, sb.pending());
      end
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
